FILE: hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants for the Base64 decoder
// Alphabet layout, result word format and the burst descriptor that moves
// decoded bytes into the output buffer.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned AlphaSize   = 64;
  localparam int unsigned AlphaWords  = 8;
  localparam int unsigned CfgWidth    = 64;
  localparam int unsigned CfgIdxWidth = 4;

  localparam logic [7:0] CharPad   = 8'h3d;  // '='
  localparam logic [7:0] CharPlus  = 8'h2b;  // '+'
  localparam logic [7:0] CharSlash = 8'h2f;  // '/'
  localparam logic [7:0] NotFound  = 8'hff;

  localparam logic CmdChar  = 1'b0;
  localparam logic CmdFlush = 1'b1;

  typedef logic [AlphaSize-1:0][7:0] alphabet_t;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       last;
  } result_t;

  // Up to three result words produced by one character word.
  typedef struct packed {
    logic [1:0]        cnt;
    result_t [2:0]     res;
  } push_t;

  typedef struct packed {
    logic [1:0] count;
    logic       stopped;
  } grp_stat_t;

endpackage

FILE: hw/rtl/base64_decoder_custom_alphabet.sv
// ----------------------------------------------------------------------------
// base64_decoder_custom_alphabet: streaming Base64 decoder, programmable map
// Character words in, decoded byte words out, alphabet in eight registers.
// ----------------------------------------------------------------------------
// One character word is accepted per clock. A word lands in an input
// register; on moving on it either joins the partial group or, on the
// fourth character or an end command, maps the whole group through the
// alphabet (four parallel 64-way compares) and writes up to three byte
// words into a four-entry output buffer; a character outside the Base64
// set instead stops decoding until the end command. The output drains one
// byte word per cycle while the receiver is ready; the input stalls only
// when the buffer cannot take the burst that the held word produces, which
// under continuous backpressure-free traffic never happens for normal
// groups (three bytes per four characters). The alphabet is read when a
// group completes or is flushed, so it may be rewritten between groups or
// while a partial group is held. Writes to register indexes above 7 are
// dropped. An end command always yields at least one word with tlast set;
// with fewer than two characters held that word has tuser (byte valid) low.
// ----------------------------------------------------------------------------
module base64_decoder_custom_alphabet
  import b64d_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // character stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] char_in
  input  logic                   s_axis_tuser,   // [0] cmd (1 = end, flush)
  // decoded byte stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [7:0] out_byte
  output logic                   m_axis_tuser,   // [0] out_valid
  output logic                   m_axis_tlast,   // out_last
  // configuration
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_data
);

  alphabet_t  alphabet;

  // input register
  logic       in_valid;
  logic       in_cmd;
  logic [7:0] in_char;

  logic       room;
  logic       take;
  logic [1:0] need;
  push_t      push;
  grp_stat_t  gstat;
  result_t    out_word;

  // ---- alphabet registers: word w holds characters 8w..8w+7, low byte first
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet <= '0;
    end else if (cfg_we && cfg_index < CfgIdxWidth'(AlphaWords)) begin
      alphabet[cfg_index[2:0]*8 +: 8] <= cfg_data;
    end
  end

  // ---- input stage: the held word moves on whenever the buffer has room
  assign take          = in_valid && room;
  assign s_axis_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd  <= s_axis_tuser;
      in_char <= s_axis_tdata;
    end
  end

  // ---- group assembly and decode
  b64d_group u_group (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .cmd      (in_cmd),
    .ch       (in_char),
    .alphabet (alphabet),
    .need     (need),
    .push     (push),
    .stat     (gstat)
  );

  // ---- result buffer
  b64d_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .need       (need),
    .push       (push),
    .room       (room),
    .out_tvalid (m_axis_tvalid),
    .out_tready (m_axis_tready),
    .out_word   (out_word)
  );

  assign m_axis_tdata = out_word.data;
  assign m_axis_tuser = out_word.vld;
  assign m_axis_tlast = out_word.last;

  // ---- checks
  // A word that cannot move on is held, not lost.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !room |=> in_valid && $stable(in_char) && $stable(in_cmd))
    else $error("input word dropped while buffer full");

  // An end command leaves an empty, running group behind.
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    take && in_cmd == CmdFlush |=> gstat.count == 2'd0 && !gstat.stopped)
    else $error("group state not cleared by end command");

  // Once stopped, characters produce nothing.
  a_stopped_quiet: assert property (@(posedge clk) disable iff (rst)
    take && in_cmd == CmdChar && gstat.stopped |-> push.cnt == 2'd0)
    else $error("output produced after decode stop");

endmodule

FILE: hw/rtl/b64d_lookup.sv
// ----------------------------------------------------------------------------
// b64d_lookup: alphabet position search
// Parallel compare against all 64 alphabet entries; the lowest matching
// position wins, no match gives 0xff.
// ----------------------------------------------------------------------------
module b64d_lookup
  import b64d_pkg::*;
(
  input  alphabet_t  alphabet,
  input  logic [7:0] ch,
  output logic [7:0] pos
);

  always_comb begin
    pos = NotFound;
    for (int p = AlphaSize - 1; p >= 0; p--) begin
      if (alphabet[p] == ch) begin
        pos = 8'(p);
      end
    end
  end

endmodule

FILE: hw/rtl/b64d_group.sv
// ----------------------------------------------------------------------------
// b64d_group: group assembly and decode
// Holds the raw characters of the partial group plus the stop flag, and
// decodes a complete or flushed group into a burst of result words.
// ----------------------------------------------------------------------------
module b64d_group
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic       cmd,
  input  logic [7:0] ch,
  input  alphabet_t  alphabet,
  output logic [1:0] need,
  output push_t      push,
  output grp_stat_t  stat
);

  logic [2:0][7:0] slots, slots_next;
  logic [1:0]      count, count_next;
  logic            stopped, stopped_next;

  logic [3:0][7:0] raw;
  logic [3:0][7:0] v;
  logic [2:0][7:0] dec;
  logic            allowed;

  assign allowed = ch inside {[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39],
                              CharPlus, CharSlash};

  // Last slot is the incoming character on a full group, zero on a flush.
  always_comb begin
    raw[0] = slots[0];
    raw[1] = slots[1];
    raw[2] = slots[2];
    raw[3] = (cmd == CmdChar) ? ch : 8'h00;
  end

  for (genvar k = 0; k < 4; k++) begin : g_map
    b64d_lookup u_lookup (
      .alphabet (alphabet),
      .ch       (raw[k]),
      .pos      (v[k])
    );
  end

  // 8-bit arithmetic: bits shifted past bit 7 drop out.
  assign dec[0] = {v[0][5:0], 2'b00} + {6'b0, v[1][5:4]};
  assign dec[1] = {v[1][3:0], 4'b0000} + {4'b0, v[2][5:2]};
  assign dec[2] = {v[2][1:0], 6'b000000} + v[3];

  // Burst size the held word would produce if taken now.
  always_comb begin
    if (cmd == CmdFlush) begin
      need = (count == 2'd3) ? 2'd2 : 2'd1;
    end else if (!stopped && allowed && count == 2'd3) begin
      need = 2'd3;
    end else begin
      need = 2'd0;
    end
  end

  always_comb begin
    slots_next   = slots;
    count_next   = count;
    stopped_next = stopped;
    push         = '0;
    if (take) begin
      if (cmd == CmdChar) begin
        if (!stopped) begin
          if (!allowed) begin
            stopped_next = 1'b1;
          end else if (count != 2'd3) begin
            slots_next[count] = ch;
            count_next        = count + 2'd1;
          end else begin
            push.cnt    = 2'd3;
            push.res[0] = '{data: dec[0], vld: 1'b1, last: 1'b0};
            push.res[1] = '{data: dec[1], vld: 1'b1, last: 1'b0};
            push.res[2] = '{data: dec[2], vld: 1'b1, last: 1'b0};
            slots_next  = '0;
            count_next  = '0;
          end
        end
      end else begin
        slots_next   = '0;
        count_next   = '0;
        stopped_next = 1'b0;
        case (count)
          2'd2: begin
            push.cnt    = 2'd1;
            push.res[0] = '{data: dec[0], vld: 1'b1, last: 1'b1};
          end
          2'd3: begin
            push.cnt    = 2'd2;
            push.res[0] = '{data: dec[0], vld: 1'b1, last: 1'b0};
            push.res[1] = '{data: dec[1], vld: 1'b1, last: 1'b1};
          end
          default: begin
            // empty or single character: bare end marker
            push.cnt    = 2'd1;
            push.res[0] = '{data: 8'h00, vld: 1'b0, last: 1'b1};
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots   <= '0;
      count   <= '0;
      stopped <= 1'b0;
    end else begin
      slots   <= slots_next;
      count   <= count_next;
      stopped <= stopped_next;
    end
  end

  assign stat = '{count: count, stopped: stopped};

endmodule

FILE: hw/rtl/b64d_outbuf.sv
// ----------------------------------------------------------------------------
// b64d_outbuf: four-entry result buffer
// Takes a burst of up to three words per cycle, hands out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module b64d_outbuf
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] need,
  input  push_t      push,
  output logic       room,
  output logic       out_tvalid,
  input  logic       out_tready,
  output result_t    out_word
);

  result_t    mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_eff;
  logic       pop;

  assign pop        = out_tvalid && out_tready;
  assign count_eff  = count - {2'b0, pop};
  assign room       = (count_eff + {1'b0, need}) <= 3'd4;
  assign out_tvalid = count != 3'd0;
  assign out_word   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.cnt >= 2'd1) mem[wr_ptr]         <= push.res[0];
    if (push.cnt >= 2'd2) mem[wr_ptr + 2'd1]  <= push.res[1];
    if (push.cnt == 2'd3) mem[wr_ptr + 2'd2]  <= push.res[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.cnt;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_eff + {1'b0, push.cnt};
    end
  end

endmodule

FILE: sim/base64_decoder_custom_alphabet_tb.sv
// ----------------------------------------------------------------------------
// base64_decoder_custom_alphabet_tb: self-checking bench for the Base64 decoder
// Drives character words and end commands under several programmed alphabets,
// predicts every decoded byte word, and checks the output stream in order.
// ----------------------------------------------------------------------------
module base64_decoder_custom_alphabet_tb;
  import b64d_pkg::*;

  // Quiet cycles (nothing moves on either stream or the config port) before
  // the run is declared hung. The longest legal quiet stretch is the forced
  // receiver hold of HoldCycles plus the pipeline.
  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 300;
  // Extra wait after the last predicted word when draining.
  localparam int DrainCycles = 8;

  typedef logic [2:0][7:0] byte_trio_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = 8'h00;   // [7:0] char_in
  logic                   s_axis_tuser = CmdChar; // [0] cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;           // [7:0] out_byte
  logic                   m_axis_tuser;           // [0] out_valid
  logic                   m_axis_tlast;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgWidth-1:0]    cfg_data = '0;

  // Shadow of the decoder: alphabet registers and the partial group.
  logic [CfgWidth-1:0] shadow_words [AlphaWords];
  logic [7:0]          shadow_slots [3];
  int                  shadow_count;
  logic                shadow_stopped;

  result_t expected_bytes [$];
  int      errors = 0;

  // Traffic knobs, written only by the test sequence.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_req      = 0;
  int hold_len      = 0;
  // Owned by the receiver process.
  int hold_seen     = 0;
  int hold_left     = 0;

  base64_decoder_custom_alphabet u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic logic [7:0] alphabet_char(input int pos);
    return shadow_words[pos >> 3][(pos & 7) * 8 +: 8];
  endfunction

  // First matching alphabet position, or not-found.
  function automatic logic [7:0] alphabet_pos(input logic [7:0] ch);
    for (int pos = 0; pos < AlphaSize; pos++) begin
      if (alphabet_char(pos) == ch) return 8'(pos);
    end
    return NotFound;
  endfunction

  function automatic logic is_b64_char(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           (c >= "0" && c <= "9") || c == CharPlus || c == CharSlash;
  endfunction

  // 8-bit arithmetic throughout: bits shifted past bit 7 are dropped.
  function automatic byte_trio_t decode_quad(input logic [3:0][7:0] quad);
    logic [7:0] v [4];
    byte_trio_t d;
    for (int k = 0; k < 4; k++) v[k] = alphabet_pos(quad[k]);
    d[0] = (v[0] << 2) + ((v[1] & 8'h30) >> 4);
    d[1] = ((v[1] & 8'h0f) << 4) + ((v[2] & 8'h3c) >> 2);
    d[2] = ((v[2] & 8'h03) << 6) + v[3];
    return d;
  endfunction

  task automatic queue_byte(input logic [7:0] data, input logic vld, input logic last);
    result_t r;
    r.data = data;
    r.vld  = vld;
    r.last = last;
    expected_bytes.push_back(r);
  endtask

  task automatic predict_decode(input logic cmd, input logic [7:0] ch);
    logic [3:0][7:0] quad;
    byte_trio_t dec;
    int held;
    held = shadow_count;
    quad = '0;
    for (int k = 0; k < held; k++) quad[k] = shadow_slots[k];
    if (cmd == CmdChar) begin
      if (shadow_stopped) return;
      if (ch == CharPad || !is_b64_char(ch)) begin
        shadow_stopped = 1'b1;   // held characters stay for the flush
        return;
      end
      if (held < 3) begin
        shadow_slots[held] = ch;
        shadow_count = held + 1;
        return;
      end
      quad[3] = ch;
      dec = decode_quad(quad);
      for (int k = 0; k < 3; k++) queue_byte(dec[k], 1'b1, 1'b0);
      for (int k = 0; k < 3; k++) shadow_slots[k] = 8'h00;
      shadow_count = 0;
    end else begin
      for (int k = 0; k < 3; k++) shadow_slots[k] = 8'h00;
      shadow_count   = 0;
      shadow_stopped = 1'b0;
      if (held < 2) begin
        queue_byte(8'h00, 1'b0, 1'b1);   // nothing to flush, marker word only
      end else begin
        dec = decode_quad(quad);
        for (int k = 0; k < held - 1; k++) queue_byte(dec[k], 1'b1, k == held - 2);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Called at a rising-edge time step; returns at the edge that took the word.
  // Ready is looked at on the falling edge, where it is settled and holds
  // until the next rising edge.
  task automatic send_word(input logic cmd, input logic [7:0] ch);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tuser  <= cmd;
    @(negedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    predict_decode(cmd, ch);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(CmdChar, s[i]);
  endtask

  // Wait for every predicted word, then let the pipeline go quiet.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [CfgWidth-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= CfgIdxWidth'(idx);
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx < AlphaWords) shadow_words[idx] = data;
  endtask

  // Program all eight words, then poke one unmapped index that must be dropped.
  task automatic load_alphabet(input alphabet_t a);
    logic [CfgWidth-1:0] w;
    drain();
    for (int i = 0; i < AlphaWords; i++) begin
      for (int k = 0; k < 8; k++) w[8 * k +: 8] = a[8 * i + k];
      write_reg(i, w);
    end
    write_reg(AlphaWords + $urandom_range(7), {$urandom, $urandom});
  endtask

  function automatic alphabet_t std_alphabet();
    alphabet_t a;
    for (int p = 0; p < AlphaSize; p++) begin
      if (p < 26)      a[p] = 8'("A" + p);
      else if (p < 52) a[p] = 8'("a" + p - 26);
      else if (p < 62) a[p] = 8'("0" + p - 52);
      else if (p == 62) a[p] = CharPlus;
      else             a[p] = CharSlash;
    end
    return a;
  endfunction

  function automatic alphabet_t shuffled_alphabet();
    alphabet_t a;
    logic [7:0] t;
    int j;
    a = std_alphabet();
    for (int i = AlphaSize - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = a[i];
      a[i] = a[j];
      a[j] = t;
    end
    return a;
  endfunction

  // Mostly characters that decode, some padding, some arbitrary bytes.
  function automatic logic [7:0] pick_char();
    alphabet_t sa;
    int r;
    sa = std_alphabet();
    r = $urandom_range(99);
    if (r < 45)      return alphabet_char($urandom_range(AlphaSize - 1));
    else if (r < 85) return sa[$urandom_range(AlphaSize - 1)];
    else if (r < 92) return CharPad;
    else             return 8'($urandom_range(255));
  endfunction

  // Strings of random length, each closed by an end command.
  task automatic run_strings(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(16) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        send_word(CmdChar, pick_char());
        sent++;
      end
      send_word(CmdFlush, 8'($urandom_range(255)));
      sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Alphabet still at reset: every allowed character maps to not-found.
  task automatic test_reset_alphabet();
    run_strings(20);
  endtask

  task automatic test_directed_standard();
    load_alphabet(std_alphabet());
    send_text("TWFu");                 // full group
    send_word(CmdFlush, 8'hff);        // nothing held
    send_text("QQ");                   // two held -> one byte
    send_word(CmdFlush, 8'h00);
    send_text("QUI");                  // three held -> two bytes
    send_word(CmdFlush, 8'hff);
    send_text("Q");                    // one held -> marker only
    send_word(CmdFlush, 8'h00);
    send_text("/+=x");                 // pad stops, later char ignored
    send_word(CmdFlush, 8'h00);
    send_text("A");
    send_word(CmdChar, 8'h80);         // high byte stops decoding
    send_word(CmdFlush, 8'hff);
    // alphabet swapped while two characters are held
    send_text("ab");
    load_alphabet(shuffled_alphabet());
    send_text("cd");
    send_word(CmdFlush, 8'h00);
  endtask

  task automatic test_random_standard();
    load_alphabet(std_alphabet());
    run_strings(40);
  endtask

  task automatic test_shuffled_alphabet();
    load_alphabet(shuffled_alphabet());
    run_strings(40);
  endtask

  // All-ones words, repeated entries (first match wins), random bytes.
  task automatic test_edge_alphabets();
    alphabet_t a;
    alphabet_t sa;
    a = '1;
    load_alphabet(a);
    run_strings(10);
    sa = std_alphabet();
    for (int p = 0; p < AlphaSize; p++) a[p] = sa[p >> 1];
    load_alphabet(a);
    run_strings(20);
    for (int p = 0; p < AlphaSize; p++) a[p] = 8'($urandom_range(255));
    load_alphabet(a);
    run_strings(20);
  endtask

  // Receiver holds off while full groups keep coming, so the output buffer
  // fills and the input must stall.
  task automatic test_backpressure();
    alphabet_t sa;
    sa = std_alphabet();
    load_alphabet(sa);
    hold_len = HoldCycles;
    hold_req++;
    for (int i = 0; i < 24; i++) send_word(CmdChar, sa[$urandom_range(AlphaSize - 1)]);
    send_word(CmdFlush, 8'($urandom_range(255)));
  endtask

  // --------------------------------------------------------------------------
  // Receiver, checker, watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Sampled on the falling edge: the word is taken at the next rising edge.
  always @(negedge clk) begin : check_bytes
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte word: out_byte %h out_valid %b out_last %b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== want.vld) begin
          $error("out_valid: expected %b, got %b", want.vld, m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("out_last: expected %b, got %b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(negedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("base64_decoder_custom_alphabet verification failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < AlphaWords; i++) shadow_words[i] = '0;
    for (int k = 0; k < 3; k++) shadow_slots[k] = 8'h00;
    shadow_count   = 0;
    shadow_stopped = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles lightly, receiver heavily
    src_idle_pct  = 20;
    sink_idle_pct = 58;
    test_reset_alphabet();
    test_directed_standard();
    test_random_standard();

    // and the other way round
    src_idle_pct  = 58;
    sink_idle_pct = 20;
    test_shuffled_alphabet();

    // full rate both sides
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_edge_alphabets();
    test_backpressure();

    drain();
    if (errors == 0 && expected_bytes.size() == 0)
      $display("base64_decoder_custom_alphabet verification clean");
    else
      $display("base64_decoder_custom_alphabet verification failed");
    $finish;
  end

endmodule
